// ===== rtl/ltr_pkg.sv =====
// Shared types, character codes and byte class helpers for the lexical token recognizer.
// Depends on nothing; lexical_token_recognizer imports it.
package ltr_pkg;

    // Token kinds, as carried on func and echoed on token_kind
    typedef enum logic [3:0] {
        KIND_TSTRING   = 4'd0,
        KIND_SSTRING   = 4'd1,
        KIND_DSTRING   = 4'd2,
        KIND_ID        = 4'd3,
        KIND_NUMBER    = 4'd4,
        KIND_INT       = 4'd5,
        KIND_HEX       = 4'd6,
        KIND_CCOMMENT  = 4'd7,
        KIND_CMCOMMENT = 4'd8,
        KIND_PYCOMMENT = 4'd9,
        KIND_WHITE     = 4'd10,
        KIND_NEWLINE   = 4'd11,
        KIND_ANY       = 4'd12
    } kind_t;

    // Phase codes: number recognizer sub-states; the block comment reuses PH_STAR
    typedef logic [2:0] phase_t;
    localparam phase_t PH_START   = 3'd0;
    localparam phase_t PH_LEAD    = 3'd1;
    localparam phase_t PH_DOTNEED = 3'd2;
    localparam phase_t PH_INT     = 3'd3;
    localparam phase_t PH_FRAC    = 3'd4;
    localparam phase_t PH_E       = 3'd5;
    localparam phase_t PH_SIGN    = 3'd6;
    localparam phase_t PH_EXPD    = 3'd7;
    localparam phase_t PH_STAR    = 3'd1;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_ID_EXTRA_LOW  = 2'd0;
    localparam cfg_index_t REG_ID_EXTRA_HIGH = 2'd1;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_X   = 8'h78;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;

    // One result beat
    typedef struct packed {
        logic [15:0] token_len;
        logic [3:0]  token_kind;
        logic        too_long;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha_(input logic [7:0] c);
        is_alpha_ = ((c >= CH_LO_A) && (c <= CH_LO_Z)) ||
                    ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_UNDER);
    endfunction

    function automatic logic is_hexd(input logic [7:0] c);
        is_hexd = is_digit(c) || ((c >= CH_LO_A) && (c <= CH_LO_F)) ||
                  ((c >= CH_UP_A) && (c <= CH_UP_F));
    endfunction

    // Extra id-like bytes from the two 64-bit masks; NUL and 128..255 never count
    function automatic logic is_extra(input logic [7:0] c, input logic [63:0] lo,
                                      input logic [63:0] hi);
        if (c == CH_NUL || c[7]) begin
            is_extra = 1'b0;
        end else if (!c[6]) begin
            is_extra = lo[c[5:0]];
        end else begin
            is_extra = hi[c[5:0]];
        end
    endfunction

endpackage

// ===== rtl/lexical_token_recognizer.sv =====
// Top level of the lexical token recognizer: byte-serial token scanner with registered output.
// Depends on ltr_pkg (kinds, phase codes, character codes, byte class functions).
//
// The block takes one text byte per clock on the s_ channel while s_ready is high. A beat
// with s_first set starts a check of kind s_func at that byte; each later byte advances a
// small phase machine in a single combinational pass from the input ports into the scan
// state registers, so a byte can be accepted every cycle that s_ready is high. When the
// answer is known, or on the beat marked s_last, one result (length consumed, kind echoed,
// saturation flag) is written into a two-entry output buffer whose head register drives the
// m_ channel. s_ready is registered and falls only while both output entries hold results
// the sink has not taken. Lengths saturate at MAX_TOKEN_LEN, and too_long is then set.
module lexical_token_recognizer
    import ltr_pkg::*;
#(
    parameter longint unsigned MAX_TOKEN_LEN = 64'd65535
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  cfg_index_t  cfg_index,
    input  logic [63:0] cfg_wdata,
    // byte channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_first,
    input  logic        s_last,
    input  logic [3:0]  s_func,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_token_len,
    output logic [3:0]  m_token_kind,
    output logic        m_too_long
);

    // Length counters hold MAX_TOKEN_LEN; at least 16 bits so token_len is a plain slice
    localparam int CLOG_W = $clog2(MAX_TOKEN_LEN + 64'd1);
    localparam int LEN_W  = (CLOG_W > 16) ? CLOG_W : 16;
    localparam int SUM_W  = LEN_W + 1;
    localparam logic [SUM_W-1:0] MAX_LEN = SUM_W'(MAX_TOKEN_LEN);

    // Configuration registers
    logic [63:0] id_extra_low_reg;
    logic [63:0] id_extra_high_reg;

    // Scan state
    logic             busy_reg, busy_next;
    kind_t            kind_reg, kind_next;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] run_len_reg, run_len_next;
    logic [LEN_W-1:0] fallback_len_reg, fallback_len_next;
    logic             quote_double_reg, quote_double_next;
    logic             skip_next_reg, skip_next_next;
    logic [1:0]       quote_run_reg, quote_run_next;

    // Output buffer
    logic    out_valid_reg, skid_valid_reg;
    result_t out_reg, skid_reg;

    logic             accept, pop, push;
    logic             done;
    logic [SUM_W-1:0] len, len_sat, p1, p2;
    logic [LEN_W-1:0] p;
    logic [7:0]       c;
    logic             lst;
    logic [7:0]       q;
    logic             idc;
    result_t          result;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;
    assign push    = accept && done;

    assign m_valid      = out_valid_reg;
    assign m_token_len  = out_reg.token_len;
    assign m_token_kind = out_reg.token_kind;
    assign m_too_long   = out_reg.too_long;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_extra_low_reg  <= '0;
            id_extra_high_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_ID_EXTRA_LOW) begin
                id_extra_low_reg <= cfg_wdata;
            end else if (cfg_index == REG_ID_EXTRA_HIGH) begin
                id_extra_high_reg <= cfg_wdata;
            end
        end
    end

    // One byte through the recognizer
    always_comb begin
        c   = s_ch;
        lst = s_last;

        // a first beat restarts the check with cleared state
        busy_next         = busy_reg;
        kind_next         = kind_reg;
        phase_next        = phase_reg;
        fallback_len_next = fallback_len_reg;
        quote_double_next = quote_double_reg;
        skip_next_next    = skip_next_reg;
        quote_run_next    = quote_run_reg;
        p                 = run_len_reg;
        if (s_first) begin
            busy_next         = 1'b1;
            kind_next         = kind_t'(s_func);
            phase_next        = PH_START;
            fallback_len_next = '0;
            quote_double_next = 1'b0;
            skip_next_next    = 1'b0;
            quote_run_next    = '0;
            p                 = '0;
        end

        p1 = {1'b0, p} + SUM_W'(1);
        p2 = {1'b0, p} + SUM_W'(2);
        run_len_next = (s_first) ? '0 : run_len_reg;
        done = 1'b0;
        len  = '0;
        q    = CH_SQUOTE;
        idc  = 1'b0;

        if (busy_next) begin
            run_len_next = (p1 > MAX_LEN) ? MAX_LEN[LEN_W-1:0] : p1[LEN_W-1:0];

            unique case (kind_next)
                KIND_TSTRING: begin
                    q = quote_double_next ? CH_DQUOTE : CH_SQUOTE;
                    if (p == '0) begin
                        if (c == CH_DQUOTE || c == CH_SQUOTE) begin
                            quote_double_next = (c == CH_DQUOTE);
                        end else begin
                            done = 1'b1;
                        end
                    end else if (p <= LEN_W'(2)) begin
                        if (c != q) begin
                            done = 1'b1;
                        end
                    end else if (skip_next_next) begin
                        skip_next_next = 1'b0;
                        quote_run_next = '0;
                    end else if (c == CH_BSLASH) begin
                        skip_next_next = 1'b1;
                        quote_run_next = '0;
                    end else if (c == q) begin
                        quote_run_next = quote_run_next + 2'd1;
                        if (quote_run_next == 2'd3) begin
                            done = 1'b1;
                            len  = p1;
                        end
                    end else begin
                        quote_run_next = '0;
                    end
                    if (!done && lst) begin
                        done = 1'b1;
                        len  = '0;
                    end
                end

                KIND_SSTRING, KIND_DSTRING: begin
                    q = (kind_next == KIND_SSTRING) ? CH_SQUOTE : CH_DQUOTE;
                    if (p == '0) begin
                        if (c != q) begin
                            done = 1'b1;
                        end
                    end else if (skip_next_next) begin
                        skip_next_next = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        skip_next_next = 1'b1;
                    end else if (c == q) begin
                        done = 1'b1;
                        len  = p1;
                    end else if (c == CH_NL) begin
                        done = 1'b1;
                    end
                    if (!done && lst) begin
                        done = 1'b1;
                        len  = '0;
                    end
                end

                KIND_ID: begin
                    idc = is_extra(c, id_extra_low_reg, id_extra_high_reg);
                    if (p == '0) begin
                        if (c == CH_NUL || (!is_alpha_(c) && !idc)) begin
                            done = 1'b1;
                        end else if (lst) begin
                            done = 1'b1;
                            len  = SUM_W'(1);
                        end
                    end else if (c != CH_NUL && (is_alpha_(c) || is_digit(c) || idc)) begin
                        if (lst) begin
                            done = 1'b1;
                            len  = p1;
                        end
                    end else begin
                        done = 1'b1;
                        len  = {1'b0, p};
                    end
                end

                KIND_NUMBER: begin
                    if (phase_next == PH_START && c == CH_MINUS) begin
                        phase_next = PH_LEAD;
                        done       = lst;
                    end else begin
                        unique case (phase_next)
                            PH_START, PH_LEAD: begin
                                if (c == CH_DOT) begin
                                    phase_next = PH_DOTNEED;
                                    done       = lst;
                                end else if (is_digit(c)) begin
                                    phase_next = PH_INT;
                                    done       = lst;
                                    len        = p1;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                            PH_DOTNEED: begin
                                if (is_digit(c)) begin
                                    phase_next = PH_FRAC;
                                    done       = lst;
                                    len        = p1;
                                end else begin
                                    done = 1'b1;
                                end
                            end
                            PH_INT, PH_FRAC: begin
                                if (is_digit(c) || (phase_next == PH_INT && c == CH_DOT)) begin
                                    if (c == CH_DOT) begin
                                        phase_next = PH_FRAC;
                                    end
                                    done = lst;
                                    len  = p1;
                                end else if (c == CH_LO_E || c == CH_UP_E) begin
                                    fallback_len_next = p;
                                    phase_next        = PH_E;
                                    done              = lst;
                                    len               = {1'b0, p};
                                end else begin
                                    done = 1'b1;
                                    len  = {1'b0, p};
                                end
                            end
                            PH_E: begin
                                if (lst) begin
                                    done = 1'b1;
                                    len  = {1'b0, fallback_len_next};
                                end else if (c == CH_PLUS || c == CH_MINUS) begin
                                    phase_next = PH_SIGN;
                                end else if (is_digit(c)) begin
                                    phase_next = PH_EXPD;
                                end else begin
                                    done = 1'b1;
                                    len  = {1'b0, fallback_len_next};
                                end
                            end
                            PH_SIGN: begin
                                if (is_digit(c)) begin
                                    phase_next = PH_EXPD;
                                    done       = lst;
                                    len        = p1;
                                end else begin
                                    done = 1'b1;
                                    len  = {1'b0, fallback_len_next};
                                end
                            end
                            default: begin
                                // exponent digits
                                if (is_digit(c)) begin
                                    done = lst;
                                    len  = p1;
                                end else begin
                                    done = 1'b1;
                                    len  = {1'b0, p};
                                end
                            end
                        endcase
                    end
                end

                KIND_INT: begin
                    if (p == '0) begin
                        if (c >= CH_ONE && c <= CH_NINE) begin
                            done = lst;
                            len  = SUM_W'(1);
                        end else begin
                            done = 1'b1;
                        end
                    end else if (is_digit(c)) begin
                        done = lst;
                        len  = p1;
                    end else begin
                        done = 1'b1;
                        len  = {1'b0, p};
                    end
                end

                KIND_HEX: begin
                    if (p == '0) begin
                        done = (c != CH_ZERO) || lst;
                    end else if (p == LEN_W'(1)) begin
                        done = (c != CH_LO_X && c != CH_UP_X) || lst;
                    end else if (p == LEN_W'(2)) begin
                        if (!is_hexd(c)) begin
                            done = 1'b1;
                        end else if (lst) begin
                            done = 1'b1;
                            len  = SUM_W'(3);
                        end
                    end else if (is_hexd(c)) begin
                        done = lst;
                        len  = p1;
                    end else begin
                        done = 1'b1;
                        len  = {1'b0, p};
                    end
                end

                KIND_CCOMMENT, KIND_PYCOMMENT: begin
                    if (p == '0) begin
                        if (kind_next == KIND_PYCOMMENT) begin
                            if (c != CH_HASH) begin
                                done = 1'b1;
                            end else if (lst) begin
                                done = 1'b1;
                                len  = SUM_W'(1);
                            end
                        end else begin
                            done = (c != CH_SLASH) || lst;
                        end
                    end else if (p == LEN_W'(1) && kind_next == KIND_CCOMMENT) begin
                        if (c != CH_SLASH) begin
                            done = 1'b1;
                        end else if (lst) begin
                            done = 1'b1;
                            len  = SUM_W'(2);
                        end
                    end else if (skip_next_next) begin
                        skip_next_next = 1'b0;
                        done           = lst;
                        len            = p1;
                    end else if (c == CH_BSLASH) begin
                        // trailing backslash counts one byte past the end
                        skip_next_next = 1'b1;
                        done           = lst;
                        len            = p2;
                    end else if (c == CH_NL || lst) begin
                        done = 1'b1;
                        len  = p1;
                    end
                end

                KIND_CMCOMMENT: begin
                    if (p == '0) begin
                        done = (c != CH_SLASH) || lst;
                    end else if (p == LEN_W'(1)) begin
                        done = (c != CH_STAR);
                    end else if (skip_next_next) begin
                        skip_next_next = 1'b0;
                        phase_next     = PH_START;
                    end else if (phase_next == PH_STAR && c == CH_SLASH) begin
                        done = 1'b1;
                        len  = p1;
                    end else begin
                        phase_next = PH_START;
                        if (c == CH_BSLASH) begin
                            skip_next_next = 1'b1;
                        end else if (c == CH_STAR) begin
                            phase_next = PH_STAR;
                        end
                    end
                    if (!done && lst) begin
                        done = 1'b1;
                        len  = '0;
                    end
                end

                KIND_WHITE: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        done = lst;
                        len  = p1;
                    end else begin
                        done = 1'b1;
                        len  = {1'b0, p};
                    end
                end

                KIND_NEWLINE: begin
                    done = 1'b1;
                    len  = (c == CH_NL) ? SUM_W'(1) : '0;
                end

                KIND_ANY: begin
                    done = 1'b1;
                    len  = SUM_W'(1);
                end

                default: begin
                    // unused kinds answer zero at once
                    done = 1'b1;
                end
            endcase

            if (done) begin
                busy_next = 1'b0;
            end
        end

        if (!done) begin
            len = '0;
        end
        len_sat           = (len > MAX_LEN) ? MAX_LEN : len;
        result.token_len  = len_sat[15:0];
        result.token_kind = kind_next;
        result.too_long   = (len_sat >= MAX_LEN);
    end

    // Scan state update on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg         <= 1'b0;
            kind_reg         <= KIND_TSTRING;
            phase_reg        <= PH_START;
            run_len_reg      <= '0;
            fallback_len_reg <= '0;
            quote_double_reg <= 1'b0;
            skip_next_reg    <= 1'b0;
            quote_run_reg    <= '0;
        end else if (accept) begin
            busy_reg         <= busy_next;
            kind_reg         <= kind_next;
            phase_reg        <= phase_next;
            run_len_reg      <= run_len_next;
            fallback_len_reg <= fallback_len_next;
            quote_double_reg <= quote_double_next;
            skip_next_reg    <= skip_next_next;
            quote_run_reg    <= quote_run_next;
        end
    end

    // Output register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_reg <= skid_reg;
            end
        end else if (push) begin
            if (!out_valid_reg || pop) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

endmodule

// ===== bench/lexical_token_recognizer_tb.sv =====
// Self-checking bench for lexical_token_recognizer: byte stream in, token lengths out.
// Depends on ltr_pkg (kinds, phase codes, character codes, register indexes, result_t)
// and on the RTL top level; a scoreboard class predicts and checks every result beat.
module lexical_token_recognizer_tb;
    import ltr_pkg::*;

    localparam int unsigned LEN_MAX          = 65535;
    localparam int unsigned QUIET_LIMIT      = 5000;
    localparam int unsigned BYTES_PER_PHASE  = 280;
    localparam logic [3:0]  KIND_UNUSED_BASE = 4'd13;

    // Token scanner prediction plus queue of expected result beats
    class token_scoreboard;
        bit [63:0]   extra_lo;
        bit [63:0]   extra_hi;
        bit          busy;
        logic [3:0]  kind;
        phase_t      phase;
        int unsigned run_len;
        int unsigned fallback_len;
        bit          quote_double;
        bit          skip_next;
        bit [1:0]    quote_run;
        bit          settled;
        int unsigned settled_len;
        result_t     expected_tokens[$];
        int          errors;

        function void set_extra(cfg_index_t idx, bit [63:0] v);
            if (idx == REG_ID_EXTRA_LOW) begin
                extra_lo = v;
            end else if (idx == REG_ID_EXTRA_HIGH) begin
                extra_hi = v;
            end
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function bit digit_ch(bit [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit letter_ch(bit [7:0] c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                   c == CH_UNDER;
        endfunction

        function bit hex_ch(bit [7:0] c);
            return digit_ch(c) || (c >= CH_LO_A && c <= CH_LO_F) ||
                   (c >= CH_UP_A && c <= CH_UP_F);
        endfunction

        // NUL and the upper half never count, whatever the masks say
        function bit extra_ch(bit [7:0] c);
            if (c == CH_NUL || c[7]) return 1'b0;
            return c[6] ? extra_hi[c[5:0]] : extra_lo[c[5:0]];
        endfunction

        function int unsigned clamp(int unsigned v);
            return (v > LEN_MAX) ? LEN_MAX : v;
        endfunction

        function void settle(int unsigned v);
            settled = 1'b1;
            settled_len = v;
        endfunction

        // Advance the scan by one accepted byte beat; queue a result if one is decided
        function void scan_byte(bit [7:0] c, bit fst, bit lst, logic [3:0] fn);
            int unsigned p;
            int unsigned len;
            bit [7:0]    q;
            result_t     r;
            settled = 1'b0;
            settled_len = 0;
            if (fst) begin
                busy = 1'b1;
                kind = fn;
                phase = PH_START;
                run_len = 0;
                fallback_len = 0;
                quote_double = 1'b0;
                skip_next = 1'b0;
                quote_run = 2'd0;
            end
            if (!busy) return;
            p = run_len;
            run_len = clamp(p + 1);

            case (kind)
                KIND_TSTRING: begin
                    q = quote_double ? CH_DQUOTE : CH_SQUOTE;
                    if (p == 0) begin
                        if (c == CH_DQUOTE || c == CH_SQUOTE) quote_double = (c == CH_DQUOTE);
                        else settle(0);
                    end else if (p <= 2) begin
                        if (c != q) settle(0);
                    end else if (skip_next) begin
                        skip_next = 1'b0;
                        quote_run = 2'd0;
                    end else if (c == CH_BSLASH) begin
                        skip_next = 1'b1;
                        quote_run = 2'd0;
                    end else if (c == q) begin
                        quote_run = quote_run + 2'd1;
                        if (quote_run == 2'd3) settle(p + 1);
                    end else begin
                        quote_run = 2'd0;
                    end
                    if (!settled && lst) settle(0);
                end
                KIND_SSTRING, KIND_DSTRING: begin
                    q = (kind == KIND_SSTRING) ? CH_SQUOTE : CH_DQUOTE;
                    if (p == 0) begin
                        if (c != q) settle(0);
                    end else if (skip_next) begin
                        skip_next = 1'b0;
                    end else if (c == CH_BSLASH) begin
                        skip_next = 1'b1;
                    end else if (c == q) begin
                        settle(p + 1);
                    end else if (c == CH_NL) begin
                        settle(0);
                    end
                    if (!settled && lst) settle(0);
                end
                KIND_ID: begin
                    if (p == 0) begin
                        if (c == CH_NUL || (!letter_ch(c) && !extra_ch(c))) settle(0);
                        else if (lst) settle(1);
                    end else if (c != CH_NUL && (letter_ch(c) || digit_ch(c) || extra_ch(c))) begin
                        if (lst) settle(p + 1);
                    end else begin
                        settle(p);
                    end
                end
                KIND_NUMBER: begin
                    if (phase == PH_START && c == CH_MINUS) begin
                        phase = PH_LEAD;
                        if (lst) settle(0);
                    end else begin
                        case (phase)
                            PH_START, PH_LEAD: begin
                                if (c == CH_DOT) begin
                                    phase = PH_DOTNEED;
                                    if (lst) settle(0);
                                end else if (digit_ch(c)) begin
                                    phase = PH_INT;
                                    if (lst) settle(p + 1);
                                end else begin
                                    settle(0);
                                end
                            end
                            PH_DOTNEED: begin
                                if (digit_ch(c)) begin
                                    phase = PH_FRAC;
                                    if (lst) settle(p + 1);
                                end else begin
                                    settle(0);
                                end
                            end
                            PH_INT, PH_FRAC: begin
                                if (digit_ch(c) || (phase == PH_INT && c == CH_DOT)) begin
                                    if (c == CH_DOT) phase = PH_FRAC;
                                    if (lst) settle(p + 1);
                                end else if (c == CH_LO_E || c == CH_UP_E) begin
                                    // remember the mantissa in case the exponent is bad
                                    fallback_len = p;
                                    phase = PH_E;
                                    if (lst) settle(fallback_len);
                                end else begin
                                    settle(p);
                                end
                            end
                            PH_E: begin
                                if (lst) settle(fallback_len);
                                else if (c == CH_PLUS || c == CH_MINUS) phase = PH_SIGN;
                                else if (digit_ch(c)) phase = PH_EXPD;
                                else settle(fallback_len);
                            end
                            PH_SIGN: begin
                                if (digit_ch(c)) begin
                                    phase = PH_EXPD;
                                    if (lst) settle(p + 1);
                                end else begin
                                    settle(fallback_len);
                                end
                            end
                            default: begin
                                if (digit_ch(c)) begin
                                    if (lst) settle(p + 1);
                                end else begin
                                    settle(p);
                                end
                            end
                        endcase
                    end
                end
                KIND_INT: begin
                    if (p == 0) begin
                        if (c >= CH_ONE && c <= CH_NINE) begin
                            if (lst) settle(1);
                        end else begin
                            settle(0);
                        end
                    end else if (digit_ch(c)) begin
                        if (lst) settle(p + 1);
                    end else begin
                        settle(p);
                    end
                end
                KIND_HEX: begin
                    if (p == 0) begin
                        if (c != CH_ZERO || lst) settle(0);
                    end else if (p == 1) begin
                        if ((c != CH_LO_X && c != CH_UP_X) || lst) settle(0);
                    end else if (p == 2) begin
                        if (!hex_ch(c)) settle(0);
                        else if (lst) settle(3);
                    end else if (hex_ch(c)) begin
                        if (lst) settle(p + 1);
                    end else begin
                        settle(p);
                    end
                end
                KIND_CCOMMENT, KIND_PYCOMMENT: begin
                    if (p == 0) begin
                        if (kind == KIND_PYCOMMENT) begin
                            if (c != CH_HASH) settle(0);
                            else if (lst) settle(1);
                        end else if (c != CH_SLASH || lst) begin
                            settle(0);
                        end
                    end else if (p == 1 && kind == KIND_CCOMMENT) begin
                        if (c != CH_SLASH) settle(0);
                        else if (lst) settle(2);
                    end else if (skip_next) begin
                        skip_next = 1'b0;
                        if (lst) settle(p + 1);
                    end else if (c == CH_BSLASH) begin
                        // a dangling backslash at the end counts one byte past the text
                        skip_next = 1'b1;
                        if (lst) settle(p + 2);
                    end else if (c == CH_NL || lst) begin
                        settle(p + 1);
                    end
                end
                KIND_CMCOMMENT: begin
                    if (p == 0) begin
                        if (c != CH_SLASH || lst) settle(0);
                    end else if (p == 1) begin
                        if (c != CH_STAR) settle(0);
                    end else if (skip_next) begin
                        skip_next = 1'b0;
                        phase = PH_START;
                    end else if (phase == PH_STAR && c == CH_SLASH) begin
                        settle(p + 1);
                    end else begin
                        phase = PH_START;
                        if (c == CH_BSLASH) skip_next = 1'b1;
                        else if (c == CH_STAR) phase = PH_STAR;
                    end
                    if (!settled && lst) settle(0);
                end
                KIND_WHITE: begin
                    if (c == CH_SPACE || c == CH_TAB) begin
                        if (lst) settle(p + 1);
                    end else begin
                        settle(p);
                    end
                end
                KIND_NEWLINE: settle((c == CH_NL) ? 1 : 0);
                KIND_ANY:     settle(1);
                default:      settle(0);
            endcase

            if (!settled) return;
            busy = 1'b0;
            len = clamp(settled_len);
            r.token_len = 16'(len);
            r.token_kind = kind;
            r.too_long = (len >= LEN_MAX);
            expected_tokens.push_back(r);
        endfunction

        // One line per mismatch
        task report_mismatch(string what);
            errors++;
            $display("ERROR: %s", what);
        endtask

        task check_result(result_t got);
            result_t want;
            if (expected_tokens.size() == 0) begin
                report_mismatch($sformatf("unexpected result len=%0d kind=%0d",
                                          got.token_len, got.token_kind));
                return;
            end
            want = expected_tokens.pop_front();
            if (got.token_len != want.token_len)
                report_mismatch($sformatf("token_len got %0d want %0d (kind %0d)",
                                          got.token_len, want.token_len, want.token_kind));
            if (got.token_kind != want.token_kind)
                report_mismatch($sformatf("token_kind got %0d want %0d",
                                          got.token_kind, want.token_kind));
            if (got.too_long != want.too_long)
                report_mismatch($sformatf("too_long got %0b want %0b (len %0d)",
                                          got.too_long, want.too_long, want.token_len));
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_index = REG_ID_EXTRA_LOW;
    logic [63:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = '0;
    logic        s_first = 1'b0;
    logic        s_last = 1'b0;
    logic [3:0]  s_func = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_token_len;
    logic [3:0]  m_token_kind;
    logic        m_too_long;

    token_scoreboard board = new;
    int unsigned     src_idle_pct = 0;
    int unsigned     sink_stall_pct = 0;
    int unsigned     sent_bytes = 0;
    int unsigned     quiet_cycles = 0;
    logic [7:0]      token_bytes[$];

    lexical_token_recognizer i_dut (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result sink: random back-pressure, driven on the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result({m_token_len, m_token_kind, m_too_long});
        end
    end

    // Watchdog: ends the run if no beat moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_digit();
        return 8'(CH_ZERO + $urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(2))
            0:       return 8'(CH_LO_A + $urandom_range(25));
            1:       return 8'(CH_UP_A + $urandom_range(25));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic logic [7:0] rand_hexd();
        case ($urandom_range(2))
            0:       return rand_digit();
            1:       return 8'(CH_LO_A + $urandom_range(5));
            default: return 8'(CH_UP_A + $urandom_range(5));
        endcase
    endfunction

    // Mostly printable, now and then any byte at all
    function automatic logic [7:0] rand_text();
        if ($urandom_range(7) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(126, 32));
    endfunction

    task automatic push_digits(input int unsigned cnt);
        repeat (cnt) token_bytes.push_back(rand_digit());
    endtask

    // One byte beat, with a random idle gap in front of it
    task automatic send_byte(input logic [7:0] c, input logic fst, input logic lst,
                             input logic [3:0] fn);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_ch <= c;
        s_first <= fst;
        s_last <= lst;
        s_func <= fn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.scan_byte(c, fst, lst, fn);
        sent_bytes++;
    endtask

    task automatic send_text(input logic [3:0] k, input string s, input bit end_last);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i], i == 0, end_last && (i == s.len() - 1),
                      (i == 0) ? k : 4'($urandom_range(15)));
        end
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_extra(input cfg_index_t idx, input logic [63:0] v);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        board.set_extra(idx, v);
    endtask

    // Force the scan idle with a last beat, drain, and let the pipeline settle
    task automatic close_phase();
        send_byte(rand_text(), 1'b1, 1'b1, KIND_ANY);
        hold_until_drained();
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed tokens with random content, plus noise and cut-off tokens
    task automatic run_random_phase(input int unsigned idle, input int unsigned stall,
                                    input logic [63:0] lo, input logic [63:0] hi);
        logic [7:0]  q;
        logic [3:0]  k;
        int unsigned n;
        int unsigned start_count;
        int          seq_no;
        bit          mark_last;
        write_extra(REG_ID_EXTRA_LOW, lo);
        write_extra(REG_ID_EXTRA_HIGH, hi);
        src_idle_pct = idle;
        sink_stall_pct = stall;
        start_count = sent_bytes;
        seq_no = 0;
        while (sent_bytes - start_count < BYTES_PER_PHASE) begin
            seq_no++;
            if (seq_no == 6 || $urandom_range(29) == 0) hold_until_drained();
            if ($urandom_range(19) == 0) begin
                // stray beat without a start
                send_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)),
                          4'($urandom_range(15)));
                continue;
            end
            k = 4'($urandom_range(15));
            n = $urandom_range(8);
            token_bytes.delete();
            case (k)
                KIND_TSTRING: begin
                    q = $urandom_range(1) ? CH_DQUOTE : CH_SQUOTE;
                    repeat (3) token_bytes.push_back(q);
                    repeat (n) begin
                        case ($urandom_range(5))
                            0: begin
                                token_bytes.push_back(CH_BSLASH);
                                token_bytes.push_back($urandom_range(1) ? q : rand_text());
                            end
                            1:       token_bytes.push_back(q);
                            default: token_bytes.push_back(rand_text());
                        endcase
                    end
                    repeat (3) token_bytes.push_back(q);
                end
                KIND_SSTRING, KIND_DSTRING: begin
                    q = (k == KIND_SSTRING) ? CH_SQUOTE : CH_DQUOTE;
                    token_bytes.push_back(q);
                    repeat (n) begin
                        case ($urandom_range(5))
                            0: begin
                                token_bytes.push_back(CH_BSLASH);
                                token_bytes.push_back($urandom_range(1) ? q : rand_text());
                            end
                            1:       token_bytes.push_back($urandom_range(5) == 0 ? CH_NL
                                                                                : rand_text());
                            default: token_bytes.push_back(rand_text());
                        endcase
                    end
                    token_bytes.push_back(q);
                end
                KIND_ID: begin
                    token_bytes.push_back($urandom_range(3) == 0 ? 8'($urandom_range(127, 1))
                                                                 : rand_letter());
                    repeat (n) begin
                        case ($urandom_range(3))
                            0:       token_bytes.push_back(rand_digit());
                            1:       token_bytes.push_back(8'($urandom_range(127, 1)));
                            default: token_bytes.push_back(rand_letter());
                        endcase
                    end
                    token_bytes.push_back(rand_text());
                end
                KIND_NUMBER: begin
                    if ($urandom_range(3) == 0) token_bytes.push_back(CH_MINUS);
                    case ($urandom_range(3))
                        0: push_digits($urandom_range(4, 1));
                        1: begin
                            push_digits($urandom_range(3, 1));
                            token_bytes.push_back(CH_DOT);
                            push_digits($urandom_range(3, 1));
                        end
                        2: begin
                            token_bytes.push_back(CH_DOT);
                            push_digits($urandom_range(3));
                        end
                        default: begin
                            push_digits($urandom_range(3, 1));
                            token_bytes.push_back(CH_DOT);
                        end
                    endcase
                    if ($urandom_range(2) == 0) begin
                        token_bytes.push_back($urandom_range(1) ? CH_LO_E : CH_UP_E);
                        if ($urandom_range(1))
                            token_bytes.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                        push_digits($urandom_range(3));
                    end
                    token_bytes.push_back(rand_text());
                end
                KIND_INT: begin
                    token_bytes.push_back($urandom_range(9) == 0 ? CH_ZERO
                                                                 : 8'(CH_ONE + $urandom_range(8)));
                    push_digits(n);
                    token_bytes.push_back(rand_text());
                end
                KIND_HEX: begin
                    token_bytes.push_back(CH_ZERO);
                    token_bytes.push_back($urandom_range(1) ? CH_LO_X : CH_UP_X);
                    repeat ($urandom_range(9) == 0 ? 0 : $urandom_range(6, 1))
                        token_bytes.push_back(rand_hexd());
                    token_bytes.push_back(rand_text());
                end
                KIND_CCOMMENT, KIND_PYCOMMENT: begin
                    if (k == KIND_CCOMMENT) begin
                        token_bytes.push_back(CH_SLASH);
                        token_bytes.push_back(CH_SLASH);
                    end else begin
                        token_bytes.push_back(CH_HASH);
                    end
                    repeat (n) begin
                        if ($urandom_range(4) == 0) begin
                            token_bytes.push_back(CH_BSLASH);
                            token_bytes.push_back($urandom_range(1) ? CH_NL : rand_text());
                        end else begin
                            token_bytes.push_back(rand_text());
                        end
                    end
                    if ($urandom_range(4) != 0) token_bytes.push_back(CH_NL);
                end
                KIND_CMCOMMENT: begin
                    token_bytes.push_back(CH_SLASH);
                    token_bytes.push_back(CH_STAR);
                    repeat (n) begin
                        case ($urandom_range(5))
                            0:       token_bytes.push_back(CH_STAR);
                            1:       token_bytes.push_back(CH_SLASH);
                            2:       token_bytes.push_back(CH_BSLASH);
                            default: token_bytes.push_back(rand_text());
                        endcase
                    end
                    token_bytes.push_back(CH_STAR);
                    token_bytes.push_back(CH_SLASH);
                end
                KIND_WHITE: begin
                    repeat (n + 1) token_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
                    token_bytes.push_back(rand_text());
                end
                KIND_NEWLINE: token_bytes.push_back($urandom_range(2) != 0 ? CH_NL : rand_text());
                default:      token_bytes.push_back(8'($urandom_range(255)));
            endcase

            // corrupt one byte or cut the token short now and then
            if ($urandom_range(7) == 0)
                token_bytes[$urandom_range(token_bytes.size() - 1)] = 8'($urandom_range(255));
            if ($urandom_range(9) == 0) begin
                while (token_bytes.size() > 1 && $urandom_range(1) != 0)
                    void'(token_bytes.pop_back());
            end
            mark_last = ($urandom_range(4) == 0);
            foreach (token_bytes[i]) begin
                send_byte(token_bytes[i], i == 0,
                          mark_last && (i == token_bytes.size() - 1),
                          (i == 0) ? k : 4'($urandom_range(15)));
            end
        end
        close_phase();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: NUL and '$' marked id-like in the mask, no idling
        write_extra(REG_ID_EXTRA_LOW, 64'h0000_0010_0000_0001);
        write_extra(REG_ID_EXTRA_HIGH, 64'h0);
        send_text(KIND_TSTRING, "'''ab'''", 1'b0);
        send_text(KIND_TSTRING, "\"\"\"x\\\"y\"\"\"", 1'b0);
        send_text(KIND_TSTRING, "''", 1'b1);
        send_text(KIND_SSTRING, "'a\\'b'", 1'b0);
        send_text(KIND_DSTRING, "\"ab\ncd\"", 1'b0);
        send_text(KIND_ID, "$ab_9 ", 1'b0);
        send_text(KIND_ID, "Zz", 1'b1);
        send_byte(8'hFF, 1'b1, 1'b0, KIND_ID);
        send_byte(CH_NUL, 1'b1, 1'b0, KIND_ID);
        send_text(KIND_ID, "a", 1'b0);
        send_byte(CH_NUL, 1'b0, 1'b0, KIND_ID);
        send_text(KIND_NUMBER, "-12.5e+3;", 1'b0);
        send_text(KIND_NUMBER, ".5 ", 1'b0);
        // exponent too close to the end falls back to the mantissa
        send_text(KIND_NUMBER, "12e", 1'b1);
        send_text(KIND_NUMBER, "7e5", 1'b1);
        send_text(KIND_NUMBER, "1e+x", 1'b0);
        send_text(KIND_NUMBER, "-.", 1'b1);
        send_text(KIND_INT, "0", 1'b0);
        send_text(KIND_INT, "907x", 1'b0);
        send_text(KIND_HEX, "0x1fG", 1'b0);
        send_text(KIND_HEX, "0X", 1'b1);
        send_text(KIND_CCOMMENT, "// a\\\nb\n", 1'b0);
        send_text(KIND_CCOMMENT, "//x\\", 1'b1);
        send_text(KIND_CMCOMMENT, "/*\\*/ **/", 1'b0);
        send_text(KIND_PYCOMMENT, "#hi\\", 1'b1);
        send_text(KIND_WHITE, " \t x", 1'b0);
        send_text(KIND_NEWLINE, "\n", 1'b0);
        send_text(KIND_NEWLINE, "a", 1'b0);
        send_text(KIND_ANY, "~", 1'b0);
        // byte outside any check is dropped
        send_byte("A", 1'b0, 1'b0, KIND_ANY);
        // unfinished identifier abandoned by a new start
        send_text(KIND_ID, "ab", 1'b0);
        send_text(KIND_INT, "5;", 1'b0);
        for (int i = 0; i < 3; i++) begin
            send_byte("q", 1'b1, i == 2, 4'(KIND_UNUSED_BASE + i));
        end
        // long whitespace run
        send_byte(CH_SPACE, 1'b1, 1'b0, KIND_WHITE);
        repeat (40) send_byte(CH_TAB, 1'b0, 1'b0, KIND_WHITE);
        send_byte("x", 1'b0, 1'b0, KIND_WHITE);
        close_phase();

        // Random phases across pacing modes and mask settings
        run_random_phase(0, 0, '1, '1);
        run_random_phase(82, 0, {$urandom, $urandom}, {$urandom, $urandom});
        run_random_phase(0, 82, '0, '0);
        run_random_phase(33, 33, {$urandom, $urandom}, {$urandom, $urandom});

        if (board.errors == 0 && board.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
